// ----- hw/rtl/rxbr_pkg.sv -----
// Shared types and constants for the receive byte ring with line extraction.
// Used by the controller, the datapath and the top level; depends on nothing.
package rxbr_pkg;

  localparam int LEN_W  = 7;
  localparam int DATA_W = 8;
  localparam int HELD_W = 8;

  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_READ      = 2'd1,
    OP_READ_LINE = 2'd2,
    OP_QUERY     = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    RS_BYTE    = 2'd0,
    RS_STORED  = 2'd1,
    RS_DROPPED = 2'd2,
    RS_NONE    = 2'd3
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // take the accepted beat into the work registers
    logic setup;      // load the burst length, clear the byte counter
    logic push;       // store the byte and present the push result
    logic resp;       // present a status-only result
    logic rd_issue;   // read the store
    logic scan_addr;  // read at read index plus byte counter
    logic emit;       // present the fetched byte and advance the read index
    logic sc_next;    // step the scan to the next stored byte
    logic sc_hit;     // delimiter found: turn the scan length into a burst
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    n_zero;
    logic    k_eq_n;
    logic    hit;
    logic    emit_last;
    logic    out_free;
  } sts_t;

endpackage

// ----- hw/rtl/rxbr_ram.sv -----
// Generic simple dual-port RAM with registered read data.
// No package dependencies; used for the byte store.
module rxbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/rxbr_ctrl.sv -----
// Sequencer for the receive byte ring: decodes each beat and steps the
// datapath through push, status, burst read and delimiter scan. Uses rxbr_pkg.
module rxbr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rxbr_pkg::sts_t sts_i,
  output rxbr_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_DECODE  = 8'b0000_0010,
    S_PUSH    = 8'b0000_0100,
    S_RESP    = 8'b0000_1000,
    S_RD_ADDR = 8'b0001_0000,
    S_RD_DATA = 8'b0010_0000,
    S_SC_ADDR = 8'b0100_0000,
    S_SC_CHK  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.setup = 1'b1;
        unique case (sts_i.op)
          rxbr_pkg::OP_PUSH:      state_d = S_PUSH;
          rxbr_pkg::OP_QUERY:     state_d = S_RESP;
          rxbr_pkg::OP_READ:      state_d = sts_i.n_zero ? S_RESP : S_RD_ADDR;
          rxbr_pkg::OP_READ_LINE: state_d = sts_i.n_zero ? S_RESP : S_SC_ADDR;
          default:                state_d = S_RESP;
        endcase
      end
      S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_RD_ADDR: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_RD_DATA;
      end
      S_RD_DATA: begin
        // hold the fetched byte until the output register frees up
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.emit_last ? S_IDLE : S_RD_ADDR;
        end
      end
      S_SC_ADDR: begin
        // scan window exhausted: no delimiter, or the line is too long
        if (sts_i.k_eq_n) begin
          state_d = S_RESP;
        end else begin
          cmd_o.rd_issue  = 1'b1;
          cmd_o.scan_addr = 1'b1;
          state_d         = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        if (sts_i.hit) begin
          cmd_o.sc_hit = 1'b1;
          state_d      = S_RD_ADDR;
        end else begin
          cmd_o.sc_next = 1'b1;
          state_d       = S_SC_ADDR;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_result_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push || cmd_o.resp || cmd_o.emit) |-> sts_i.out_free)
    else $error("result loaded while output register busy");

  a_push_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push || cmd_o.resp) |=> !in_stall_o)
    else $error("controller not idle after single-result beat");

  a_hit_starts_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.sc_hit |=> cmd_o.rd_issue && !cmd_o.scan_addr)
    else $error("delimiter hit did not start burst read");

endmodule

// ----- hw/rtl/rxbr_datapath.sv -----
// Datapath of the receive byte ring: indices, byte store, scan counter and
// the output register. Uses rxbr_pkg and rxbr_ram; driven by rxbr_ctrl.
module rxbr_datapath #(
  parameter int RING_DEPTH = 256,
  parameter int MAX_BURST  = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rxbr_pkg::cmd_t               cmd_i,
  output rxbr_pkg::sts_t               sts_o,
  input  logic [1:0]                   opcode_i,
  input  logic [rxbr_pkg::DATA_W-1:0]  byte_in_i,
  input  logic [rxbr_pkg::LEN_W-1:0]   max_len_i,
  input  logic [rxbr_pkg::DATA_W-1:0]  delim_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [rxbr_pkg::DATA_W-1:0]  data_byte_o,
  output logic                         last_o,
  output logic [1:0]                   status_o,
  output logic [rxbr_pkg::HELD_W-1:0]  bytes_held_o
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int LW    = rxbr_pkg::LEN_W;
  localparam int DW    = rxbr_pkg::DATA_W;
  localparam int HW    = rxbr_pkg::HELD_W;
  localparam int NW    = (IDX_W > LW) ? IDX_W : LW;
  localparam int CW    = (IDX_W > HW) ? IDX_W : HW;
  localparam logic [LW-1:0] BURST = LW'(MAX_BURST);

  function automatic logic [HW-1:0] sat_held(input logic [IDX_W-1:0] c);
    logic [CW-1:0] ce;
    ce = CW'(c);
    return (ce > CW'({HW{1'b1}})) ? {HW{1'b1}} : ce[HW-1:0];
  endfunction

  rxbr_pkg::opcode_e op_q;
  logic [DW-1:0]     byte_q, delim_q;
  logic [LW-1:0]     limit_q, n_q, k_q;
  logic [IDX_W-1:0]  rd_q, wr_q;

  logic                out_valid_q;
  logic [DW-1:0]       out_data_q;
  logic                out_last_q;
  rxbr_pkg::status_e   out_status_q;
  logic [HW-1:0]       out_held_q;

  logic [IDX_W-1:0] count, wr_inc, rd_after_push, raddr;
  logic             full_push;
  logic [NW-1:0]    count_n, limit_n, n_sel;
  logic [LW-1:0]    n_w, k_inc;
  logic [DW-1:0]    rdata;
  logic             out_free, load;

  assign count         = wr_q - rd_q;
  assign wr_inc        = wr_q + IDX_W'(1);
  assign full_push     = (wr_inc == rd_q);
  assign rd_after_push = full_push ? rd_q + IDX_W'(1) : rd_q;

  assign count_n = NW'(count);
  assign limit_n = NW'(limit_q);
  assign n_sel   = (count_n < limit_n) ? count_n : limit_n;
  assign n_w     = n_sel[LW-1:0];
  assign k_inc   = k_q + LW'(1);

  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = cmd_i.push || cmd_i.resp || cmd_i.emit;
  assign raddr    = cmd_i.scan_addr ? rd_q + IDX_W'(k_q) : rd_q;

  rxbr_ram #(
    .WIDTH (DW),
    .DEPTH (RING_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (wr_q),
    .wdata_i (byte_q),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    sts_o.op        = op_q;
    sts_o.n_zero    = (n_w == '0);
    sts_o.k_eq_n    = (k_q == n_q);
    sts_o.hit       = (rdata == delim_q);
    sts_o.emit_last = (k_inc == n_q);
    sts_o.out_free  = out_free;
  end

  // Work registers of the current beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= rxbr_pkg::opcode_e'(opcode_i);
      byte_q  <= byte_in_i;
      delim_q <= delim_i;
      limit_q <= (max_len_i > BURST) ? BURST : max_len_i;
    end
    if (cmd_i.setup) begin
      n_q <= n_w;
    end else if (cmd_i.sc_hit) begin
      n_q <= k_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      k_q  <= '0;
    end else begin
      if (cmd_i.push) begin
        wr_q <= wr_inc;
        rd_q <= rd_after_push;
      end else if (cmd_i.emit) begin
        rd_q <= rd_q + IDX_W'(1);
      end
      if (cmd_i.setup || cmd_i.sc_hit) begin
        k_q <= '0;
      end else if (cmd_i.emit || cmd_i.sc_next) begin
        k_q <= k_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_data_q   <= '0;
      out_last_q   <= 1'b1;
      out_status_q <= full_push ? rxbr_pkg::RS_DROPPED : rxbr_pkg::RS_STORED;
      out_held_q   <= sat_held(wr_inc - rd_after_push);
    end else if (cmd_i.resp) begin
      out_data_q   <= '0;
      out_last_q   <= 1'b1;
      out_status_q <= rxbr_pkg::RS_NONE;
      out_held_q   <= sat_held(count);
    end else if (cmd_i.emit) begin
      out_data_q   <= rdata;
      out_last_q   <= (k_inc == n_q);
      out_status_q <= rxbr_pkg::RS_BYTE;
      out_held_q   <= sat_held(count - IDX_W'(1));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_byte_o  = out_data_q;
  assign last_o       = out_last_q;
  assign status_o     = out_status_q;
  assign bytes_held_o = out_held_q;

  a_emit_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit || cmd_i.sc_hit || cmd_i.sc_next) |-> (k_q < n_q))
    else $error("byte counter outside burst or scan window");

  a_emit_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (count != '0))
    else $error("byte emitted from empty ring");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

// ----- hw/rtl/rx_byte_ring_with_line_extract_unit.sv -----
// Top level of the receive byte ring with line extraction.
// Joins rxbr_ctrl and rxbr_datapath; uses rxbr_pkg.
//
// Input channel: one beat carries opcode, byte_in, max_len and delim. A push
// stores a byte (dropping the oldest when the ring already holds
// RING_DEPTH-1 bytes); a read returns up to max_len of the oldest bytes
// (max_len capped at MAX_BURST); a line read returns the bytes up to and
// including the first delimiter; a query reports the fill.
// Output channel: one beat per delivered byte with last on the final one,
// otherwise a single status beat. bytes_held saturates at 255.
// Timing: push, query and empty reads pass through the decode state and load
// their result into the output register once it is free, then return to idle.
// Reads deliver each byte by a store read, then the output load; the next store read waits for that load.
// A line read first scans the stored bytes one by one, a store read and a
// compare each, up to the smaller of the fill and the capped max_len.
// The next input beat is taken once the sequencer is back to idle; the last
// result may still wait in the output register meanwhile.
// Output stall: the output register holds its beat and the sequencer waits.
// Reset: the ring reads empty, both channels idle; stored data is not cleared.
module rx_byte_ring_with_line_extract_unit #(
  parameter int RING_DEPTH = 256,
  parameter int MAX_BURST  = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [rxbr_pkg::DATA_W-1:0] byte_in_i,
  input  logic [rxbr_pkg::LEN_W-1:0]  max_len_i,
  input  logic [rxbr_pkg::DATA_W-1:0] delim_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rxbr_pkg::DATA_W-1:0] data_byte_o,
  output logic                        last_o,
  output logic [1:0]                  status_o,
  output logic [rxbr_pkg::HELD_W-1:0] bytes_held_o
);

  rxbr_pkg::cmd_t cmd;
  rxbr_pkg::sts_t sts;

  rxbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rxbr_datapath #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_BURST  (MAX_BURST)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .opcode_i     (opcode_i),
    .byte_in_i    (byte_in_i),
    .max_len_i    (max_len_i),
    .delim_i      (delim_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .data_byte_o  (data_byte_o),
    .last_o       (last_o),
    .status_o     (status_o),
    .bytes_held_o (bytes_held_o)
  );

endmodule
